// ===== sv/bqc_pkg.sv =====
// ----------------------------------------------------------------------------
// bqc_pkg
// Types, constants and fixed-point helpers for the cascaded biquad filter.
// ----------------------------------------------------------------------------
package bqc_pkg;

  localparam int SMP_W            = 24;
  localparam int COEF_W           = 32;
  localparam int GAIN_W           = 32;
  localparam int ACT_W            = 4;
  localparam int FUNC_W           = 2;
  localparam int CIDX_W           = 5;
  localparam int HIST_W           = 40;
  localparam int ACC_W            = 48;
  localparam int CFG_IDX_W        = 1;
  localparam int CFG_DATA_W       = 32;
  localparam int TERMS            = 4;
  localparam int QUEUE_DEPTH      = 2;
  localparam int MAX_SECTIONS_DEF = 8;

  localparam int MUL_B_W   = 21;
  localparam int HALF_SH   = 20;
  localparam int COEF_FRAC = 27;
  localparam int COEF_RND  = 1 << (COEF_FRAC - 1);
  localparam int GAIN_SH   = 16;
  localparam int GAIN_RND  = 1 << (GAIN_SH - 1);
  localparam int OUT_SH    = 8;
  localparam int OUT_RND   = 1 << (OUT_SH - 1);

  localparam logic [GAIN_W-1:0] GAIN_RST = 32'h0100_0000;
  localparam logic [ACT_W-1:0]  ACT_RST  = '0;

  localparam logic [FUNC_W-1:0] FUNC_FILTER = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_COEF   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE = 1'd1;

  localparam logic [1:0] TERM_A1 = 2'd0;
  localparam logic [1:0] TERM_A2 = 2'd1;
  localparam logic [1:0] TERM_B1 = 2'd2;
  localparam logic [1:0] TERM_B2 = 2'd3;

  typedef enum logic [1:0] {
    CMD_FILTER,
    CMD_CLEAR,
    CMD_COEF
  } cmd_kind_t;

  typedef struct packed {
    logic [FUNC_W-1:0]        func;
    logic signed [SMP_W-1:0]  sample_in;
    logic [CIDX_W-1:0]        coef_index;
    logic signed [COEF_W-1:0] coef_value;
  } in_item_t;

  typedef struct packed {
    logic signed [SMP_W-1:0] sample_out;
    logic                    saturated;
  } out_item_t;

  typedef struct packed {
    cmd_kind_t                kind;
    logic signed [SMP_W-1:0]  sample;
    logic [CIDX_W-1:0]        coef_addr;
    logic signed [COEF_W-1:0] coef_value;
  } cmd_t;

  typedef struct packed {
    logic signed [GAIN_W-1:0] gain;
    logic [ACT_W-1:0]         active;
  } cfg_t;

  function automatic logic signed [HIST_W-1:0] sat_hist(input logic signed [ACC_W-1:0] x);
    logic all_ones;
    logic all_zeros;
    all_ones  = &x[ACC_W-1:HIST_W-1];
    all_zeros = ~(|x[ACC_W-1:HIST_W-1]);
    if (all_ones || all_zeros) begin
      sat_hist = x[HIST_W-1:0];
    end else if (x[ACC_W-1]) begin
      sat_hist = {1'b1, {(HIST_W-1){1'b0}}};
    end else begin
      sat_hist = {1'b0, {(HIST_W-1){1'b1}}};
    end
  endfunction

  function automatic out_item_t round_out(input logic signed [HIST_W-1:0] y);
    logic signed [HIST_W:0]        r;
    logic signed [HIST_W-OUT_SH:0] q;
    logic                          all_ones;
    logic                          all_zeros;
    out_item_t                     o;
    r         = (HIST_W+1)'(y) + (HIST_W+1)'(OUT_RND);
    q         = r[HIST_W:OUT_SH];
    all_ones  = &q[HIST_W-OUT_SH:SMP_W-1];
    all_zeros = ~(|q[HIST_W-OUT_SH:SMP_W-1]);
    if (all_ones || all_zeros) begin
      o.sample_out = q[SMP_W-1:0];
      o.saturated  = 1'b0;
    end else if (q[HIST_W-OUT_SH]) begin
      o.sample_out = {1'b1, {(SMP_W-1){1'b0}}};
      o.saturated  = 1'b1;
    end else begin
      o.sample_out = {1'b0, {(SMP_W-1){1'b1}}};
      o.saturated  = 1'b1;
    end
    round_out = o;
  endfunction

endpackage

// ===== sv/bqc_ram.sv =====
// ----------------------------------------------------------------------------
// bqc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bqc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/bqc_front.sv =====
// ----------------------------------------------------------------------------
// bqc_front
// Input side: accepts items, turns them into commands and drops no-ops.
// ----------------------------------------------------------------------------
module bqc_front #(
  parameter int MAX_SECTIONS = bqc_pkg::MAX_SECTIONS_DEF
) (
  input  logic              in_valid,
  output logic              in_ready,
  input  bqc_pkg::in_item_t in_data,
  input  logic              q_full,
  output logic              q_push,
  output bqc_pkg::cmd_t     q_cmd
);
  import bqc_pkg::*;

  localparam int CW  = $clog2(MAX_SECTIONS * TERMS);
  localparam int IXW = (CW + 1 > CIDX_W) ? CW + 1 : CIDX_W;

  logic [IXW-1:0] idx_ext;
  logic           idx_ok;
  logic           keep;

  assign idx_ext = IXW'(in_data.coef_index);
  assign idx_ok  = idx_ext < IXW'(MAX_SECTIONS * TERMS);

  always_comb begin
    keep             = 1'b0;
    q_cmd.kind       = CMD_FILTER;
    q_cmd.sample     = in_data.sample_in;
    q_cmd.coef_addr  = in_data.coef_index;
    q_cmd.coef_value = in_data.coef_value;
    case (in_data.func)
      FUNC_FILTER: begin
        keep = 1'b1;
      end
      FUNC_CLEAR: begin
        keep       = 1'b1;
        q_cmd.kind = CMD_CLEAR;
      end
      FUNC_COEF: begin
        keep       = idx_ok;
        q_cmd.kind = CMD_COEF;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign in_ready = ~q_full;
  assign q_push   = in_valid & ~q_full & keep;

endmodule

// ===== sv/bqc_queue.sv =====
// ----------------------------------------------------------------------------
// bqc_queue
// Short command queue between the input side and the filter engine.
// ----------------------------------------------------------------------------
module bqc_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  bqc_pkg::cmd_t push_cmd,
  output logic          full,
  output logic          valid,
  input  logic          pop,
  output bqc_pkg::cmd_t head
);
  import bqc_pkg::*;

  localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  cmd_t           mem_r [QUEUE_DEPTH];
  logic [QAW-1:0] wr_ptr_r;
  logic [QAW-1:0] rd_ptr_r;
  logic [QAW:0]   count_r;
  logic [QAW:0]   count_nxt;

  assign full  = (count_r == (QAW+1)'(QUEUE_DEPTH));
  assign valid = (count_r != '0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== sv/bqc_back.sv =====
// ----------------------------------------------------------------------------
// bqc_back
// Filter engine: gain stage, section sweep on one shared multiplier, output
// rounding and the output register.
// ----------------------------------------------------------------------------
module bqc_back #(
  parameter int MAX_SECTIONS = bqc_pkg::MAX_SECTIONS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  bqc_pkg::cfg_t      cfg,
  input  logic               q_valid,
  input  bqc_pkg::cmd_t      q_data,
  output logic               q_pop,
  input  logic               out_ready,
  output logic               out_valid,
  output bqc_pkg::out_item_t out_data
);
  import bqc_pkg::*;

  localparam int KW        = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
  localparam int CW        = $clog2(MAX_SECTIONS * TERMS);
  localparam int NW0       = $clog2(MAX_SECTIONS + 1);
  localparam int NW        = (NW0 > ACT_W) ? NW0 : ACT_W;
  localparam int PW        = COEF_W + MUL_B_W;
  localparam int XW        = PW + HALF_SH + 1;
  localparam int TW        = XW - COEF_FRAC;
  localparam int GPW       = GAIN_W + SMP_W;
  localparam int MUL_STEPS = 2 * TERMS;
  localparam int CNT_LAST  = MUL_STEPS + 2;
  localparam int CNTW      = $clog2(CNT_LAST + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_GAIN,
    S_GSAT,
    S_HIST,
    S_RUN,
    S_OUT
  } state_t;

  state_t                    state_r, state_nxt;
  logic [NW-1:0]             k_r;
  logic [CNTW-1:0]           cnt_r;
  logic [MAX_SECTIONS-1:0]   vld_r;
  logic                      out_valid_r;
  out_item_t                 out_data_r;
  logic                      mul_v_r;
  logic                      term_v_r;

  logic signed [SMP_W-1:0]   smp_r;
  logic signed [GPW-1:0]     gp_r;
  logic signed [HIST_W-1:0]  y_r;
  logic signed [HIST_W-1:0]  w_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [PW-1:0]      mul_r;
  logic                      mul_hf_r;
  logic [1:0]                mul_t_r;
  logic signed [PW-1:0]      pl_r;
  logic signed [TW-1:0]      term_r;
  logic [1:0]                term_t_r;

  logic [NW-1:0]             n_sec;
  logic [KW-1:0]             k_idx;
  logic [NW-1:0]             k_inc;
  logic [CNTW-1:0]           cnt_ahead;
  logic [1:0]                t_cur;
  logic                      hf_cur;
  logic [1:0]                t_rd;
  logic                      mul_go;
  logic                      run_end;
  logic                      out_load;
  logic                      pop_filter;
  logic                      pop_clear;

  logic [CW-1:0]             coef_raddr;
  logic [COEF_W-1:0]         coef_rdata;
  logic signed [COEF_W-1:0]  coef_rd;
  logic                      coef_we;
  logic [2*HIST_W-1:0]       hist_rdata;
  logic                      hist_we;
  logic signed [HIST_W-1:0]  h1;
  logic signed [HIST_W-1:0]  h2;
  logic signed [HIST_W-1:0]  h_sel;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PW-1:0]      mul_p;
  logic signed [XW-1:0]      xsum;
  logic signed [TW-1:0]      term_nxt;
  logic signed [HIST_W-1:0]  w_sat;
  logic signed [GPW-1:0]     gp_p;
  logic signed [GPW:0]       g_rnd;
  logic signed [HIST_W:0]    g_sh;

  assign n_sec     = (NW'(cfg.active) > NW'(MAX_SECTIONS)) ? NW'(MAX_SECTIONS)
                                                           : NW'(cfg.active);
  assign k_idx     = k_r[KW-1:0];
  assign k_inc     = k_r + 1'b1;
  assign cnt_ahead = cnt_r + 1'b1;
  assign t_cur     = cnt_r[2:1];
  assign hf_cur    = cnt_r[0];
  assign t_rd      = (state_r == S_RUN) ? cnt_ahead[2:1] : TERM_A1;
  assign mul_go    = (state_r == S_RUN) && (cnt_r < CNTW'(MUL_STEPS));
  assign run_end   = (state_r == S_RUN) && (cnt_r == CNTW'(CNT_LAST));
  assign out_load  = (state_r == S_OUT) && (!out_valid_r || out_ready);
  assign q_pop     = (state_r == S_IDLE) && q_valid;
  assign pop_filter = q_pop && (q_data.kind == CMD_FILTER);
  assign pop_clear  = q_pop && (q_data.kind == CMD_CLEAR);

  assign coef_we    = q_pop && (q_data.kind == CMD_COEF);
  assign coef_raddr = CW'({k_idx, t_rd});
  assign coef_rd    = coef_rdata;
  assign hist_we    = run_end;

  bqc_ram #(
    .WIDTH (COEF_W),
    .DEPTH (MAX_SECTIONS * TERMS)
  ) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (CW'(q_data.coef_addr)),
    .wdata (q_data.coef_value),
    .raddr (coef_raddr),
    .rdata (coef_rdata)
  );

  bqc_ram #(
    .WIDTH (2 * HIST_W),
    .DEPTH (MAX_SECTIONS)
  ) u_hist_ram (
    .clk   (clk),
    .we    (hist_we),
    .waddr (k_idx),
    .wdata ({w_r, h1}),
    .raddr (k_idx),
    .rdata (hist_rdata)
  );

  assign h1    = vld_r[k_idx] ? hist_rdata[2*HIST_W-1:HIST_W] : '0;
  assign h2    = vld_r[k_idx] ? hist_rdata[HIST_W-1:0] : '0;
  assign h_sel = t_cur[0] ? h2 : h1;
  assign mul_b = hf_cur ? {h_sel[HIST_W-1], h_sel[HIST_W-1:HALF_SH]}
                        : {1'b0, h_sel[HALF_SH-1:0]};
  assign mul_p = coef_rd * mul_b;

  assign xsum     = (XW'(mul_r) <<< HALF_SH) + XW'(pl_r) + XW'(COEF_RND);
  assign term_nxt = xsum[XW-1:COEF_FRAC];
  assign w_sat    = sat_hist(acc_r);

  assign gp_p  = cfg.gain * smp_r;
  assign g_rnd = (GPW+1)'(gp_r) + (GPW+1)'(GAIN_RND);
  assign g_sh  = g_rnd[GPW:GAIN_SH];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (pop_filter) begin
          state_nxt = S_GAIN;
        end
      end
      S_GAIN: begin
        state_nxt = S_GSAT;
      end
      S_GSAT: begin
        state_nxt = (n_sec == '0) ? S_OUT : S_HIST;
      end
      S_HIST: begin
        state_nxt = S_RUN;
      end
      S_RUN: begin
        if (run_end) begin
          state_nxt = (k_inc == n_sec) ? S_OUT : S_HIST;
        end
      end
      S_OUT: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      k_r         <= '0;
      cnt_r       <= '0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
      mul_v_r     <= 1'b0;
      term_v_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      mul_v_r  <= mul_go;
      term_v_r <= mul_v_r && mul_hf_r;
      if (state_r == S_GSAT) begin
        k_r <= '0;
      end else if (run_end) begin
        k_r <= k_inc;
      end
      if (state_r == S_HIST) begin
        cnt_r <= '0;
      end else if (state_r == S_RUN) begin
        cnt_r <= cnt_ahead;
      end
      if (pop_clear) begin
        vld_r <= '0;
      end else if (hist_we) begin
        vld_r[k_idx] <= 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (out_load) begin
        out_data_r <= round_out(y_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop_filter) begin
      smp_r <= q_data.sample;
    end
    if (state_r == S_GAIN) begin
      gp_r <= gp_p;
    end
    if (state_r == S_GSAT) begin
      y_r <= sat_hist(ACC_W'(g_sh));
    end else if (run_end) begin
      y_r <= w_sat;
    end
    mul_r    <= mul_p;
    mul_hf_r <= hf_cur;
    mul_t_r  <= t_cur;
    if (mul_v_r && !mul_hf_r) begin
      pl_r <= mul_r;
    end
    if (mul_v_r && mul_hf_r) begin
      term_r   <= term_nxt;
      term_t_r <= mul_t_r;
    end
    if (state_r == S_HIST) begin
      acc_r <= ACC_W'(y_r);
    end else if (term_v_r) begin
      case (term_t_r)
        TERM_A1, TERM_A2: begin
          acc_r <= acc_r - ACC_W'(term_r);
        end
        TERM_B1: begin
          w_r   <= w_sat;
          acc_r <= ACC_W'(w_sat) + ACC_W'(term_r);
        end
        TERM_B2: begin
          acc_r <= acc_r + ACC_W'(term_r);
        end
        default: begin
          acc_r <= acc_r;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== sv/biquad_cascade_iir_filter_core.sv =====
// ----------------------------------------------------------------------------
// biquad_cascade_iir_filter_core
// A new sample is taken only after the previous result is in the output register.
// Each section runs eight 32x21 products through the one shared multiplier plus a
//   three-stage drain. Clear and coefficient items act as they leave the queue;
//   the input queue holds two.
// Reset (synchronous, rst_n low): history reads as zero, gain 1.0, no sections;
//   coefficients are undefined until written.
// ----------------------------------------------------------------------------
module biquad_cascade_iir_filter_core #(
  parameter int MAX_SECTIONS = bqc_pkg::MAX_SECTIONS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  bqc_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output bqc_pkg::out_item_t                out_data,
  input  logic                              cfg_we,
  input  logic [bqc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bqc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import bqc_pkg::*;

  cfg_t cfg_r;
  logic q_push;
  cmd_t q_cmd;
  logic q_full;
  logic q_valid;
  logic q_pop;
  cmd_t q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain   <= GAIN_RST;
      cfg_r.active <= ACT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GAIN: begin
          cfg_r.gain <= cfg_wdata[GAIN_W-1:0];
        end
        REG_ACTIVE: begin
          cfg_r.active <= cfg_wdata[ACT_W-1:0];
        end
        default: begin
          cfg_r <= cfg_r;
        end
      endcase
    end
  end

  bqc_front #(
    .MAX_SECTIONS (MAX_SECTIONS)
  ) u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_cmd)
  );

  bqc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .valid    (q_valid),
    .pop      (q_pop),
    .head     (q_head)
  );

  bqc_back #(
    .MAX_SECTIONS (MAX_SECTIONS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_data    (q_head),
    .q_pop     (q_pop),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ===== tb/sv/biquad_cascade_iir_filter_core_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// biquad_cascade_iir_filter_core_test
// Self-checking bench for the cascaded biquad filter core. A fixed-point
// model of the gain stage, the direct form II sections and the output
// rounding tracks every accepted item and predicts each filtered sample.
// Directed items cover the sample and gain extremes, saturation, clear, the
// spare function code and coefficient extremes. Random phases then vary
// gain and section count, reload sections and clear history, while the
// input side sends in bursts and the output side stalls on its own pattern.
// ----------------------------------------------------------------------------

class filter_tracker;
  typedef logic signed [79:0] acc_t;

  logic signed [31:0]  gain;
  logic [3:0]          sections;
  logic signed [31:0]  coef_store [bqc_pkg::MAX_SECTIONS_DEF*4];
  logic signed [39:0]  history [bqc_pkg::MAX_SECTIONS_DEF*2];
  bqc_pkg::out_item_t  pending_outputs[$];
  int                  errors;
  int                  checked;
  int                  clipped;

  function new();
    gain     = 32'sh0100_0000;
    sections = '0;
    foreach (coef_store[i]) coef_store[i] = '0;
    foreach (history[i]) history[i] = '0;
    errors   = 0;
    checked  = 0;
    clipped  = 0;
  endfunction

  function acc_t clip(acc_t x, int bits);
    acc_t top;
    acc_t bot;
    top = (acc_t'(1) <<< (bits - 1)) - 1;
    bot = -top - 1;
    if (x > top) return top;
    if (x < bot) return bot;
    return x;
  endfunction

  // coefficient Q4.27 times history Q8.31, rounded back to Q8.31
  function acc_t weigh(logic signed [31:0] c, logic signed [39:0] h);
    acc_t p;
    p = acc_t'(c) * acc_t'(h);
    return (p + (acc_t'(1) <<< 26)) >>> 27;
  endfunction

  function bqc_pkg::out_item_t filter_sample(logic signed [23:0] sample);
    acc_t               y;
    acc_t               w;
    acc_t               r;
    logic signed [39:0] h1;
    logic signed [39:0] h2;
    int                 n;
    int                 base;
    bqc_pkg::out_item_t o;
    y = acc_t'(gain) * acc_t'(sample);
    y = clip((y + (acc_t'(1) <<< 15)) >>> 16, 40);
    n = (sections > bqc_pkg::MAX_SECTIONS_DEF) ? bqc_pkg::MAX_SECTIONS_DEF
                                               : int'(sections);
    for (int k = 0; k < n; k++) begin
      base = 4 * k;
      h1 = history[2*k];
      h2 = history[2*k+1];
      w = clip(y - weigh(coef_store[base + int'(bqc_pkg::TERM_A1)], h1)
                 - weigh(coef_store[base + int'(bqc_pkg::TERM_A2)], h2), 40);
      y = clip(w + weigh(coef_store[base + int'(bqc_pkg::TERM_B1)], h1)
                 + weigh(coef_store[base + int'(bqc_pkg::TERM_B2)], h2), 40);
      history[2*k+1] = h1;
      history[2*k]   = w[39:0];
    end
    y = (y + (acc_t'(1) <<< 7)) >>> 8;
    r = clip(y, 24);
    o.sample_out = r[23:0];
    o.saturated  = (r != y);
    return o;
  endfunction

  function void note_item(bqc_pkg::in_item_t item);
    case (item.func)
      bqc_pkg::FUNC_FILTER:
        pending_outputs.insert(pending_outputs.size(),
                               filter_sample($signed(item.sample_in)));
      bqc_pkg::FUNC_CLEAR: foreach (history[i]) history[i] = '0;
      bqc_pkg::FUNC_COEF: begin
        if (int'(item.coef_index) < bqc_pkg::MAX_SECTIONS_DEF * 4)
          coef_store[item.coef_index] = item.coef_value;
      end
      default: ;
    endcase
  endfunction

  task report_mismatch(string what);
    if (errors < 30) $display("%0t ns mismatch: %s", $time, what);
    errors++;
  endtask

  task check_output(bqc_pkg::out_item_t got);
    bqc_pkg::out_item_t want;
    if (pending_outputs.size() == 0) begin
      report_mismatch($sformatf("unexpected sample %0d", $signed(got.sample_out)));
    end else begin
      want = pending_outputs.pop_front();
      checked++;
      if (want.saturated) clipped++;
      if (got.sample_out !== want.sample_out)
        report_mismatch($sformatf("sample_out %0d, expected %0d",
                                  $signed(got.sample_out), $signed(want.sample_out)));
      if (got.saturated !== want.saturated)
        report_mismatch($sformatf("saturated %b, expected %b",
                                  got.saturated, want.saturated));
    end
  endtask
endclass

module biquad_cascade_iir_filter_core_test;
  import bqc_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;
  localparam int ITEM_TARGET   = 2000;
  localparam int SETTLE_CYCLES = 120;
  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam logic signed [31:0] GAIN_MAX  = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] GAIN_MIN  = 32'sh8000_0000;
  localparam logic signed [31:0] GAIN_UNIT = 32'sh0100_0000;
  localparam logic signed [23:0] SMP_MAX   = 24'sh7F_FFFF;
  localparam logic signed [23:0] SMP_MIN   = 24'sh80_0000;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  filter_tracker tracker = new();
  int            cycle_count = 0;
  int            burst_left  = 0;
  int            items_sent  = 0;
  int            stall_mode  = 0;
  int            stall_left  = 0;

  biquad_cascade_iir_filter_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("biquad_cascade_iir_filter_core_test: done, errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) tracker.check_output(out_data);
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(50, 400);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      2: out_ready <= ($urandom_range(0, 4) == 0);
      default: out_ready <= cycle_count[4];
    endcase
  end

  task automatic push_item(input in_item_t item);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    tracker.note_item(item);
    if (item.func != FUNC_SPARE) items_sent++;
  endtask

  task automatic send_op(input logic [FUNC_W-1:0] func, input logic signed [23:0] sample,
                         input logic [4:0] index, input logic signed [31:0] value);
    in_item_t item;
    item.func       = func;
    item.sample_in  = sample;
    item.coef_index = index;
    item.coef_value = value;
    push_item(item);
  endtask

  task automatic send_sample(input logic signed [23:0] sample);
    send_op(FUNC_FILTER, sample, 5'($urandom), $urandom);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.pending_outputs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(input logic signed [31:0] gain, input logic [3:0] active);
    cfg_we    <= 1'b1;
    cfg_index <= REG_GAIN;
    cfg_wdata <= gain;
    @(posedge clk);
    tracker.gain = gain;
    cfg_index <= REG_ACTIVE;
    cfg_wdata <= {28'($urandom), active};
    @(posedge clk);
    tracker.sections = active;
    cfg_we <= 1'b0;
  endtask

  function automatic logic signed [31:0] pick_coef(input bit mild);
    if (mild) return int'($urandom_range(0, 32'h07FF_FFFF)) - 32'sh0400_0000;
    return $urandom;
  endfunction

  function automatic logic signed [23:0] pick_sample();
    case ($urandom_range(0, 7))
      0: case ($urandom_range(0, 3))
           0: return SMP_MAX;
           1: return SMP_MIN;
           2: return '0;
           default: return -24'sd1;
         endcase
      1: return 24'(int'($urandom_range(0, 255)) - 128);
      default: return 24'($urandom);
    endcase
  endfunction

  initial begin
    int  phases;
    int  r;
    int  k;
    bit  mild;
    logic signed [31:0] gain;
    logic [3:0]         active;
    phases = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // gain only, reset settings
    send_sample('0);
    send_sample(SMP_MAX);
    send_sample(SMP_MIN);
    send_sample(24'sd1);
    send_sample(-24'sd1);
    send_sample(24'sh55_5555);
    send_sample(24'shAA_AAAA);
    send_op(FUNC_SPARE, 24'($urandom), 5'($urandom), $urandom);
    send_op(FUNC_CLEAR, 24'($urandom), 5'($urandom), $urandom);

    drain();
    write_config(GAIN_MAX, 4'd0);
    send_sample(SMP_MAX);
    send_sample(SMP_MIN);
    send_sample(24'sd1);
    drain();
    write_config(GAIN_MIN, 4'd0);
    send_sample(SMP_MAX);
    send_sample(SMP_MIN);

    // load every coefficient, extremes in the last section
    for (int i = 0; i < MAX_SECTIONS_DEF * 4; i++)
      send_op(FUNC_COEF, 24'($urandom), 5'(i),
              (i == 30) ? GAIN_MIN : (i == 31) ? GAIN_MAX : pick_coef(1'b1));
    drain();
    write_config(GAIN_UNIT, 4'd15);
    send_sample(SMP_MAX);
    send_sample(SMP_MIN);
    send_sample('0);
    send_sample(24'sd12345);

    while (items_sent < ITEM_TARGET) begin
      drain();
      phases++;
      case ($urandom_range(0, 5))
        0: gain = GAIN_MAX;
        1: gain = GAIN_MIN;
        2: gain = GAIN_UNIT;
        3: gain = int'($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000;
        default: gain = $urandom;
      endcase
      case ($urandom_range(0, 4))
        0: active = 4'd0;
        1: active = 4'd1;
        2: active = 4'd8;
        3: active = 4'd15;
        default: active = 4'($urandom_range(0, 15));
      endcase
      write_config(gain, active);
      if ($urandom_range(0, 1) == 1) send_op(FUNC_CLEAR, 24'($urandom), 5'($urandom), $urandom);
      repeat ($urandom_range(100, 250)) begin
        r = $urandom_range(0, 99);
        if (r < 85) begin
          send_sample(pick_sample());
        end else if (r < 92) begin
          k    = $urandom_range(0, MAX_SECTIONS_DEF - 1);
          mild = ($urandom_range(0, 9) < 7);
          for (int t = 0; t < TERMS; t++)
            send_op(FUNC_COEF, 24'($urandom), 5'(4 * k + t), pick_coef(mild));
        end else if (r < 97) begin
          send_op(FUNC_CLEAR, 24'($urandom), 5'($urandom), $urandom);
        end else begin
          send_op(FUNC_SPARE, 24'($urandom), 5'($urandom), $urandom);
        end
      end
    end

    drain();
    $display("%0d items accepted over %0d random phases plus directed setup",
             items_sent, phases);
    $display("%0d filtered samples checked, %0d of them clipped at the output",
             tracker.checked, tracker.clipped);
    if (tracker.errors == 0) begin
      $display("biquad_cascade_iir_filter_core_test: done, clean");
    end else begin
      $display("%0d mismatches", tracker.errors);
      $display("biquad_cascade_iir_filter_core_test: done, errors");
    end
    $finish;
  end

endmodule
